FILE: rtl/core/clut_pkg.sv
package clut_pkg;

   // Palette geometry; the entry count is a power of two so the index wraps
   localparam int PAL_AW      = 10;
   localparam int PAL_ENTRIES = 1 << PAL_AW;

   // Field widths
   localparam int IDX_W   = 10;             // entry_index and palette_base
   localparam int COLOR_W = 16;
   localparam int TEXEL_W = 8;
   localparam int CH5_W   = 5;
   localparam int CH_W    = 8;
   localparam int GAIN_W  = 12;
   localparam int PROD_W  = CH_W + GAIN_W;
   localparam int SUM_W   = IDX_W + 1;      // base plus texel before wrapping

   // Request beat layout
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 32;

   // Request kinds carried on tuser
   localparam logic FUNC_WRITE   = 1'b0;
   localparam logic FUNC_CONVERT = 1'b1;

   // Register indexes on the csr port
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = GAIN_W;
   localparam logic [CSR_IDX_W-1:0] CSR_EIGHT_BIT_MODE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PALETTE_BASE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MODULATE_ENABLE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RED_GAIN        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GREEN_GAIN      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BLUE_GAIN       = 3'd5;

   localparam logic [GAIN_W-1:0] GAIN_UNITY = 12'd256;

   localparam logic [CH_W-1:0] CH_MAX       = 8'd255;
   localparam logic [CH_W-1:0] ALPHA_CLEAR  = 8'd0;
   localparam logic [CH_W-1:0] ALPHA_SEMI   = 8'd127;
   localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'd255;

   // c*255/31, rounded down
   localparam logic [CH_W-1:0] EXPAND_LUT [32] = '{
      8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
      8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
      8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
      8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
   };

endpackage

FILE: rtl/core/clut_texel_to_rgba.sv
// Palette (CLUT) texel converter.
// req beats: tuser = 0 writes one palette entry, tuser = 1 converts a texel byte.
// A write gives no rsp beat. A convert gives one pixel in 8-bit mode, or two
// in 4-bit mode (low nibble first); tlast marks the final pixel of the byte.
// csr: index/data write channel, always ready; write it only while idle.
// Pipeline: a req beat passes the palette read, the expand and gain multiply, and
// the saturate and alpha stage, each registered, before its pixel shows on rsp.
// Throughput: one req beat per cycle for writes and 8-bit converts while the rsp
// side does not stall; a 4-bit convert holds req_tready low until its high-nibble
// read is issued, set by the single read port of the palette memory.
// Reset: registers take their defaults and the palette is cleared to zero, one
// entry per cycle, over all PAL_ENTRIES (1024) entries; req_tready stays low
// until it ends, csr writes are taken throughout.
// Stall: each pipeline stage holds its beat while the next one is full, so a
// stalled rsp side backs up through the stages before req_tready drops; the
// output register keeps rsp_tdata and rsp_tlast stable while it waits.
module clut_texel_to_rgba (
   input  logic                                 clock,
   input  logic                                 reset,
   // req_tdata: entry_index[9:0], entry_color[25:10], texel_byte[33:26], zero pad
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [clut_pkg::REQ_DATA_W-1:0]      req_tdata,
   // req_tuser: func
   input  logic                                 req_tuser,
   // rsp_tdata: red[7:0], green[15:8], blue[23:16], alpha[31:24]
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [clut_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tlast,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [clut_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [clut_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int AW = clut_pkg::PAL_AW;

   // ---------------- configuration registers ----------------
   logic                               mode8_ff;
   logic [clut_pkg::IDX_W-1:0]         base_ff;
   logic                               mod_en_ff;
   logic [clut_pkg::GAIN_W-1:0]        red_gain_ff;
   logic [clut_pkg::GAIN_W-1:0]        green_gain_ff;
   logic [clut_pkg::GAIN_W-1:0]        blue_gain_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode8_ff      <= 1'b0;
         base_ff       <= '0;
         mod_en_ff     <= 1'b0;
         red_gain_ff   <= clut_pkg::GAIN_UNITY;
         green_gain_ff <= clut_pkg::GAIN_UNITY;
         blue_gain_ff  <= clut_pkg::GAIN_UNITY;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            clut_pkg::CSR_EIGHT_BIT_MODE:  mode8_ff      <= csr_data[0];
            clut_pkg::CSR_PALETTE_BASE:    base_ff       <= csr_data[clut_pkg::IDX_W-1:0];
            clut_pkg::CSR_MODULATE_ENABLE: mod_en_ff     <= csr_data[0];
            clut_pkg::CSR_RED_GAIN:        red_gain_ff   <= csr_data;
            clut_pkg::CSR_GREEN_GAIN:      green_gain_ff <= csr_data;
            clut_pkg::CSR_BLUE_GAIN:       blue_gain_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------- request unpack ----------------
   logic [clut_pkg::IDX_W-1:0]    entry_index;
   logic [clut_pkg::COLOR_W-1:0]  entry_color;
   logic [clut_pkg::TEXEL_W-1:0]  texel_byte;

   assign entry_index = req_tdata[9:0];
   assign entry_color = req_tdata[25:10];
   assign texel_byte  = req_tdata[33:26];

   // ---------------- control state ----------------
   logic           clr_busy_ff;
   logic [AW-1:0]  clr_addr_ff;
   logic           hi_pend_ff;      // high nibble of a 4-bit byte still to read
   logic [AW-1:0]  hi_idx_ff;

   logic s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic s1_ready, s2_ready, out_ready;

   assign out_ready = !rsp_valid_ff || rsp_tready;
   assign s2_ready  = !s2_valid_ff || out_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;

   assign req_tready = !clr_busy_ff && !hi_pend_ff && s1_ready;

   logic req_accept, wr_accept, conv_accept;
   assign req_accept  = req_tvalid && req_tready;
   assign wr_accept   = req_accept && (req_tuser == clut_pkg::FUNC_WRITE);
   assign conv_accept = req_accept && (req_tuser == clut_pkg::FUNC_CONVERT);

   // Palette indexes, wrapping at the palette size
   logic [clut_pkg::TEXEL_W-1:0]  lo_texel;
   logic [clut_pkg::SUM_W-1:0]    lo_sum, hi_sum;
   logic [AW-1:0]                 lo_idx, hi_idx_in;

   assign lo_texel  = mode8_ff ? texel_byte : {4'b0000, texel_byte[3:0]};
   assign lo_sum    = clut_pkg::SUM_W'(base_ff) + clut_pkg::SUM_W'(lo_texel);
   assign hi_sum    = clut_pkg::SUM_W'(base_ff) + clut_pkg::SUM_W'(texel_byte[7:4]);
   assign lo_idx    = AW'(lo_sum);
   assign hi_idx_in = AW'(hi_sum);

   // Read issue: the byte's first pixel on accept, the second once stage 1 can take it
   logic           rd_en;
   logic [AW-1:0]  rd_addr;
   logic           rd_last;

   assign rd_en   = conv_accept || (hi_pend_ff && s1_ready);
   assign rd_addr = hi_pend_ff ? hi_idx_ff : lo_idx;
   assign rd_last = hi_pend_ff ? 1'b1 : mode8_ff;

   // Write port: clearing pass after reset, then palette write beats.
   // A read is always issued at a later edge than any write before it,
   // so the memory needs no forwarding.
   logic                          mem_we;
   logic [AW-1:0]                 mem_waddr;
   logic [clut_pkg::COLOR_W-1:0]  mem_wdata;

   assign mem_we    = clr_busy_ff || wr_accept;
   assign mem_waddr = clr_busy_ff ? clr_addr_ff : AW'(entry_index);
   assign mem_wdata = clr_busy_ff ? '0 : entry_color;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
         hi_pend_ff  <= 1'b0;
      end else begin
         if (clr_busy_ff) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
            if (clr_addr_ff == AW'(clut_pkg::PAL_ENTRIES - 1)) begin
               clr_busy_ff <= 1'b0;
            end
         end
         if (conv_accept && !mode8_ff) begin
            hi_pend_ff <= 1'b1;
         end else if (hi_pend_ff && s1_ready) begin
            hi_pend_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (conv_accept) begin
         hi_idx_ff <= hi_idx_in;
      end
   end

   // ---------------- palette memory, stage 1 ----------------
   logic [clut_pkg::COLOR_W-1:0] palette_mem [clut_pkg::PAL_ENTRIES];
   logic [clut_pkg::COLOR_W-1:0] s1_color_ff;
   logic                         s1_last_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         palette_mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         s1_color_ff <= palette_mem[rd_addr];
         s1_last_ff  <= rd_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= rd_en;
      end
   end

   // ---------------- stage 2: expand and gain ----------------
   logic [clut_pkg::CH_W-1:0]    r8, g8, b8;
   logic [clut_pkg::GAIN_W-1:0]  r_gain, g_gain, b_gain;
   logic [clut_pkg::PROD_W-1:0]  r_prod_in, g_prod_in, b_prod_in;
   logic [clut_pkg::PROD_W-1:0]  r_prod_ff, g_prod_ff, b_prod_ff;
   logic                         s2_zero_ff, s2_semi_ff, s2_last_ff;

   assign r8 = clut_pkg::EXPAND_LUT[s1_color_ff[4:0]];
   assign g8 = clut_pkg::EXPAND_LUT[s1_color_ff[9:5]];
   assign b8 = clut_pkg::EXPAND_LUT[s1_color_ff[14:10]];

   // Unity gain when modulation is off keeps one datapath
   assign r_gain = mod_en_ff ? red_gain_ff   : clut_pkg::GAIN_UNITY;
   assign g_gain = mod_en_ff ? green_gain_ff : clut_pkg::GAIN_UNITY;
   assign b_gain = mod_en_ff ? blue_gain_ff  : clut_pkg::GAIN_UNITY;

   assign r_prod_in = clut_pkg::PROD_W'(r8) * clut_pkg::PROD_W'(r_gain);
   assign g_prod_in = clut_pkg::PROD_W'(g8) * clut_pkg::PROD_W'(g_gain);
   assign b_prod_in = clut_pkg::PROD_W'(b8) * clut_pkg::PROD_W'(b_gain);

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s2_ready) begin
         r_prod_ff  <= r_prod_in;
         g_prod_ff  <= g_prod_in;
         b_prod_ff  <= b_prod_in;
         s2_zero_ff <= (s1_color_ff == '0);
         s2_semi_ff <= s1_color_ff[15];
         s2_last_ff <= s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // ---------------- stage 3: saturate, alpha, output register ----------------
   localparam int HI_W = clut_pkg::PROD_W - 8;

   logic [HI_W-1:0]            r_hi, g_hi, b_hi;
   logic [clut_pkg::CH_W-1:0]  red_in, green_in, blue_in, alpha_in;
   logic [clut_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic                       rsp_last_ff;

   assign r_hi = r_prod_ff[clut_pkg::PROD_W-1:8];
   assign g_hi = g_prod_ff[clut_pkg::PROD_W-1:8];
   assign b_hi = b_prod_ff[clut_pkg::PROD_W-1:8];

   assign red_in   = (r_hi > HI_W'(clut_pkg::CH_MAX)) ? clut_pkg::CH_MAX : r_hi[7:0];
   assign green_in = (g_hi > HI_W'(clut_pkg::CH_MAX)) ? clut_pkg::CH_MAX : g_hi[7:0];
   assign blue_in  = (b_hi > HI_W'(clut_pkg::CH_MAX)) ? clut_pkg::CH_MAX : b_hi[7:0];

   // Transparent for a raw zero entry; semitransparent only if some channel survives
   always_comb begin
      if (s2_zero_ff) begin
         alpha_in = clut_pkg::ALPHA_CLEAR;
      end else if (s2_semi_ff && ((red_in | green_in | blue_in) != '0)) begin
         alpha_in = clut_pkg::ALPHA_SEMI;
      end else begin
         alpha_in = clut_pkg::ALPHA_OPAQUE;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff && out_ready) begin
         rsp_data_ff <= {alpha_in, blue_in, green_in, red_in};
         rsp_last_ff <= s2_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: rtl/core/clut_port_checker.sv
module clut_port_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [clut_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                             rsp_tlast
);

   // Clearing pass keeps the request side closed right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("req_tready high right after reset");

   // Nothing comes out of a freshly reset pipeline
   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp beat right after reset");

   // A stalled beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp beat changed while stalled");

   // The second pixel of a byte is always right behind the first
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("second pixel of a byte not ready after the first");

endmodule

bind clut_texel_to_rgba clut_port_checker u_port_checker (.*);

FILE: dv/clut_texel_to_rgba_test.sv
module clut_texel_to_rgba_test;

   localparam int CLK_PERIOD = 10;
   // Generous bound: the slowest legal run stays far below this many cycles
   localparam int RUN_LIMIT_CYCLES = 1_000_000;
   // Cycles to let a palette write settle before a register write
   localparam int SETTLE_CYCLES = 8;

   // One request beat before packing
   typedef struct packed {
      logic                         func;
      logic [clut_pkg::IDX_W-1:0]   entry_index;
      logic [clut_pkg::COLOR_W-1:0] entry_color;
      logic [clut_pkg::TEXEL_W-1:0] texel_byte;
   } req_item_type;

   // One predicted output pixel
   typedef struct packed {
      logic [clut_pkg::CH_W-1:0] red;
      logic [clut_pkg::CH_W-1:0] green;
      logic [clut_pkg::CH_W-1:0] blue;
      logic [clut_pkg::CH_W-1:0] alpha;
      logic                      last;
   } pixel_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   // req_tdata: entry_index, entry_color, texel_byte, zero pad (lowest bit up)
   logic [clut_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   // req_tuser: func
   logic                            req_tuser = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   // rsp_tdata: red, green, blue, alpha (lowest bit up)
   logic [clut_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tlast;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [clut_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [clut_pkg::CSR_DATA_W-1:0] csr_data = '0;

   clut_texel_to_rgba uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Mirror of the block's registers and palette, updated on accepted beats
   logic                         mode_8b;
   logic [clut_pkg::IDX_W-1:0]   pal_base;
   logic                         mod_en;
   logic [clut_pkg::GAIN_W-1:0]  gains [3];        // red, green, blue
   logic [clut_pkg::COLOR_W-1:0] pal_mirror [clut_pkg::PAL_ENTRIES];

   req_item_type req_backlog [$];        // beats waiting for the driver
   pixel_type    expected_pixels [$];    // pixels predicted, not yet seen

   // Handshake flags seen at the last rising edge, read by the drivers
   logic req_taken = 1'b0;
   logic csr_taken = 1'b0;
   // Set for phases that run with no idling on either side
   logic steady = 1'b0;

   int queued_items = 0;
   int accepted_items = 0;
   int writes_seen = 0;
   int converts_seen = 0;
   int pixels_checked = 0;
   int settings_used = 0;
   int fail_count = 0;

   int           req_gap = 0;
   int           rsp_hold = 0;
   req_item_type drv_beat;

   // Mostly short idles, now and then a long one
   function automatic int idle_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(1, 2);
      if (roll < 95) return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   // Palette lookup, 5-bit to 8-bit expansion, optional gain and alpha rule
   function automatic pixel_type lookup_pixel(logic [clut_pkg::TEXEL_W-1:0] texel,
                                              logic is_last);
      logic [clut_pkg::IDX_W-1:0]   idx;
      logic [clut_pkg::COLOR_W-1:0] col;
      int                           ch [3];
      pixel_type                    px;
      idx = pal_base + clut_pkg::IDX_W'(texel);    // wraps at PAL_ENTRIES
      col = pal_mirror[idx];
      for (int k = 0; k < 3; k++) begin
         ch[k] = int'(col[k*clut_pkg::CH5_W +: clut_pkg::CH5_W]) * int'(clut_pkg::CH_MAX)
                 / ((1 << clut_pkg::CH5_W) - 1);
         if (mod_en) begin
            ch[k] = (ch[k] * int'(gains[k])) >> 8;
            if (ch[k] > int'(clut_pkg::CH_MAX)) ch[k] = int'(clut_pkg::CH_MAX);
         end
      end
      px.red   = clut_pkg::CH_W'(ch[0]);
      px.green = clut_pkg::CH_W'(ch[1]);
      px.blue  = clut_pkg::CH_W'(ch[2]);
      // Raw zero is see-through; flag on a visible color is half see-through
      if (col == '0) px.alpha = clut_pkg::ALPHA_CLEAR;
      else if (col[clut_pkg::COLOR_W-1] && (ch[0] | ch[1] | ch[2]) != 0)
         px.alpha = clut_pkg::ALPHA_SEMI;
      else px.alpha = clut_pkg::ALPHA_OPAQUE;
      px.last = is_last;
      return px;
   endfunction

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   // Monitor: tracks register and palette writes, predicts and checks pixels
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         csr_taken <= 1'b0;
         mode_8b = 1'b0;
         pal_base = '0;
         mod_en = 1'b0;
         gains = '{clut_pkg::GAIN_UNITY, clut_pkg::GAIN_UNITY, clut_pkg::GAIN_UNITY};
         foreach (pal_mirror[i]) pal_mirror[i] = '0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         csr_taken <= csr_valid && csr_ready;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               clut_pkg::CSR_EIGHT_BIT_MODE:  mode_8b = csr_data[0];
               clut_pkg::CSR_PALETTE_BASE:    pal_base = csr_data[clut_pkg::IDX_W-1:0];
               clut_pkg::CSR_MODULATE_ENABLE: mod_en = csr_data[0];
               clut_pkg::CSR_RED_GAIN:        gains[0] = csr_data;
               clut_pkg::CSR_GREEN_GAIN:      gains[1] = csr_data;
               clut_pkg::CSR_BLUE_GAIN:       gains[2] = csr_data;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pixels.size() == 0) begin
               $error("rsp beat with no pixel expected: tdata %h tlast %b",
                      rsp_tdata, rsp_tlast);
               fail_count++;
            end else begin
               pixel_type want;
               want = expected_pixels.pop_front();
               check_field("red",   want.red,   rsp_tdata[0 +: clut_pkg::CH_W]);
               check_field("green", want.green, rsp_tdata[clut_pkg::CH_W +: clut_pkg::CH_W]);
               check_field("blue",  want.blue,
                           rsp_tdata[2*clut_pkg::CH_W +: clut_pkg::CH_W]);
               check_field("alpha", want.alpha,
                           rsp_tdata[3*clut_pkg::CH_W +: clut_pkg::CH_W]);
               check_field("last",  want.last,  rsp_tlast);
               pixels_checked++;
            end
         end
         if (req_tvalid && req_tready) begin
            logic [clut_pkg::TEXEL_W-1:0] texel;
            accepted_items++;
            texel = req_tdata[clut_pkg::IDX_W+clut_pkg::COLOR_W +: clut_pkg::TEXEL_W];
            if (req_tuser == clut_pkg::FUNC_WRITE) begin
               pal_mirror[req_tdata[clut_pkg::IDX_W-1:0]] =
                  req_tdata[clut_pkg::IDX_W +: clut_pkg::COLOR_W];
               writes_seen++;
            end else if (mode_8b) begin
               expected_pixels.push_back(lookup_pixel(texel, 1'b1));
               converts_seen++;
            end else begin
               // 4-bit mode: low nibble first, high nibble closes the byte
               expected_pixels.push_back(
                  lookup_pixel(clut_pkg::TEXEL_W'(texel[3:0]), 1'b0));
               expected_pixels.push_back(
                  lookup_pixel(clut_pkg::TEXEL_W'(texel[7:4]), 1'b1));
               converts_seen++;
            end
         end
      end
   end

   // req driver: holds a beat until taken, then maybe idles before the next
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else if (req_tvalid && !req_taken) begin
         // beat still waiting for tready
      end else if (req_gap > 0) begin
         req_gap--;
         req_tvalid <= 1'b0;
      end else if (req_backlog.size() != 0) begin
         drv_beat = req_backlog.pop_front();
         req_tuser  <= drv_beat.func;
         req_tdata  <= clut_pkg::REQ_DATA_W'({drv_beat.texel_byte, drv_beat.entry_color,
                                              drv_beat.entry_index});
         req_tvalid <= 1'b1;
         req_gap = (steady || $urandom_range(0, 2) != 0) ? 0 : idle_len();
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // rsp side: random stalls of random length
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold = 0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
         rsp_hold = idle_len() - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic void queue_write(logic [clut_pkg::IDX_W-1:0] idx,
                                       logic [clut_pkg::COLOR_W-1:0] color);
      req_item_type it;
      it.func        = clut_pkg::FUNC_WRITE;
      it.entry_index = idx;
      it.entry_color = color;
      it.texel_byte  = clut_pkg::TEXEL_W'($urandom);     // unused by a write
      req_backlog.push_back(it);
      queued_items++;
   endfunction

   function automatic void queue_convert(logic [clut_pkg::TEXEL_W-1:0] texel);
      req_item_type it;
      it.func        = clut_pkg::FUNC_CONVERT;
      it.entry_index = clut_pkg::IDX_W'($urandom);       // unused by a convert
      it.entry_color = clut_pkg::COLOR_W'($urandom);
      it.texel_byte  = texel;
      req_backlog.push_back(it);
      queued_items++;
   endfunction

   // Writes all six registers back to back over the csr channel
   task automatic set_config(input logic eight, input logic [clut_pkg::IDX_W-1:0] base,
                             input logic mod, input logic [clut_pkg::GAIN_W-1:0] rg,
                             input logic [clut_pkg::GAIN_W-1:0] gg,
                             input logic [clut_pkg::GAIN_W-1:0] bg);
      logic [clut_pkg::CSR_IDX_W-1:0]  idx [6];
      logic [clut_pkg::CSR_DATA_W-1:0] val [6];
      idx = '{clut_pkg::CSR_EIGHT_BIT_MODE, clut_pkg::CSR_PALETTE_BASE,
              clut_pkg::CSR_MODULATE_ENABLE, clut_pkg::CSR_RED_GAIN,
              clut_pkg::CSR_GREEN_GAIN, clut_pkg::CSR_BLUE_GAIN};
      val = '{clut_pkg::CSR_DATA_W'(eight), clut_pkg::CSR_DATA_W'(base),
              clut_pkg::CSR_DATA_W'(mod), rg, gg, bg};
      @(negedge clock);
      for (int i = 0; i < 6; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= val[i];
         do @(negedge clock); while (!csr_taken);
      end
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // Sender stops until every beat is taken and every pixel is back, then the
   // pipeline idles for SETTLE_CYCLES so a trailing palette write lands too
   task automatic drain();
      while (accepted_items != queued_items || expected_pixels.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic random_settings();
      logic [clut_pkg::GAIN_W-1:0] g [3];
      logic [clut_pkg::IDX_W-1:0]  base;
      for (int k = 0; k < 3; k++) begin
         case ($urandom_range(0, 4))
            0: g[k] = clut_pkg::GAIN_UNITY;
            1: g[k] = '0;
            2: g[k] = '1;
            3: g[k] = clut_pkg::GAIN_W'($urandom_range(128, 512));
            default: g[k] = clut_pkg::GAIN_W'($urandom);
         endcase
      end
      case ($urandom_range(0, 3))
         0: base = '0;
         1: base = '1;
         default: base = clut_pkg::IDX_W'($urandom);
      endcase
      set_config(1'($urandom_range(0, 1)), base, 1'($urandom_range(0, 1)),
                 g[0], g[1], g[2]);
   endtask

   // Mix of palette writes and converts; writes mostly land where the current
   // base and mode will read them back
   task automatic random_batch(int n);
      logic [clut_pkg::IDX_W-1:0]   idx;
      logic [clut_pkg::COLOR_W-1:0] color;
      int                           roll;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) < 3) begin
            roll = $urandom_range(0, 9);
            if (roll < 7)
               idx = pal_base + clut_pkg::IDX_W'(mode_8b ? $urandom_range(0, 255)
                                                         : $urandom_range(0, 15));
            else
               idx = clut_pkg::IDX_W'($urandom);
            case ($urandom_range(0, 9))
               0: color = '0;
               1: color = 16'h8000;
               default: color = clut_pkg::COLOR_W'($urandom);
            endcase
            queue_write(idx, color);
         end else begin
            queue_convert(clut_pkg::TEXEL_W'($urandom));
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // 4-bit mode, no gain; first convert reads the cleared palette
      set_config(1'b0, '0, 1'b0, clut_pkg::GAIN_UNITY, clut_pkg::GAIN_UNITY,
                 clut_pkg::GAIN_UNITY);
      queue_convert(8'h00);
      queue_write(10'd0,    16'h7FFF);    // white
      queue_write(10'd1,    16'h801F);    // red with the flag
      queue_write(10'd2,    16'h8000);    // flag on black
      queue_write(10'd3,    16'h001F);    // plain red
      queue_write(10'd15,   16'hFFFF);
      queue_write(10'd1023, 16'h03E0);    // green, top entry
      queue_write(10'd16,   16'h7C00);    // blue
      queue_convert(8'h10);
      queue_convert(8'h32);
      queue_convert(8'hF0);
      queue_convert(8'hFF);
      drain();

      // 8-bit mode at the top base: index wraps past the last entry
      set_config(1'b1, '1, 1'b0, clut_pkg::GAIN_UNITY, clut_pkg::GAIN_UNITY,
                 clut_pkg::GAIN_UNITY);
      queue_convert(8'h00);
      queue_convert(8'h01);
      queue_convert(8'h11);
      queue_convert(8'hFF);
      drain();

      // zero gains: visible colors turn black, alpha stays opaque
      set_config(1'b0, '0, 1'b1, '0, '0, '0);
      queue_convert(8'h10);
      queue_convert(8'h32);
      drain();

      // full-scale gains saturate every lit channel
      set_config(1'b1, '0, 1'b1, '1, '1, '1);
      queue_convert(8'h0F);
      queue_convert(8'h03);
      queue_convert(8'h01);
      queue_convert(8'h10);
      drain();

      // random phases, each drained midway so the sender waits on results
      for (int p = 0; p < 8; p++) begin
         random_settings();
         steady <= (p == 3 || p == 6);
         random_batch(56);
         drain();
         random_batch(56);
         drain();
      end

      $display("covered %0d texel bytes and %0d palette writes under %0d register settings",
               converts_seen, writes_seen, settings_used);
      $display("checked %0d pixels", pixels_checked);
      if (fail_count == 0) begin
         $display("clut_texel_to_rgba_test passed");
      end else begin
         $display("clut_texel_to_rgba_test failed");
      end
      $finish;
   end

   initial begin
      #(CLK_PERIOD * RUN_LIMIT_CYCLES);
      $display("run timed out with %0d pixels outstanding", expected_pixels.size());
      $display("clut_texel_to_rgba_test failed");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/clut_pkg.sv
rtl/core/clut_texel_to_rgba.sv
rtl/core/clut_port_checker.sv
dv/clut_texel_to_rgba_test.sv
